[rtl/core/hck_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hck_pkg: shared types and constants of the hex calculator key engine
// Command, operator and entry codes, controller state and control structs.
// ----------------------------------------------------------------------------
package hck_pkg;

	localparam logic [3:0] CMD_DIGIT   = 4'd0;
	localparam logic [3:0] CMD_GIGA    = 4'd1;
	localparam logic [3:0] CMD_MEGA    = 4'd2;
	localparam logic [3:0] CMD_KILO    = 4'd3;
	localparam logic [3:0] CMD_INVERT  = 4'd4;
	localparam logic [3:0] CMD_OPER    = 4'd5;
	localparam logic [3:0] CMD_EQUALS  = 4'd6;
	localparam logic [3:0] CMD_CLEAR   = 4'd7;
	localparam logic [3:0] CMD_CLR_ENT = 4'd8;
	localparam logic [3:0] CMD_WIDTH   = 4'd9;
	localparam logic [3:0] CMD_FORMAT  = 4'd10;

	localparam logic [3:0] OP_AND  = 4'd0;
	localparam logic [3:0] OP_OR   = 4'd1;
	localparam logic [3:0] OP_XOR  = 4'd2;
	localparam logic [3:0] OP_SHL  = 4'd3;
	localparam logic [3:0] OP_SHR  = 4'd4;
	localparam logic [3:0] OP_ADD  = 4'd5;
	localparam logic [3:0] OP_SUB  = 4'd6;
	localparam logic [3:0] OP_MUL  = 4'd7;
	localparam logic [3:0] OP_DIV  = 4'd8;
	localparam logic [3:0] OP_NONE = 4'd15;

	localparam logic [1:0] ST_RESULT  = 2'd0;
	localparam logic [1:0] ST_NOVALUE = 2'd1;
	localparam logic [1:0] ST_INPUT   = 2'd2;

	localparam logic [63:0] K_GIGA = 64'h4000_0000;
	localparam logic [63:0] K_MEGA = 64'h10_0000;
	localparam logic [63:0] K_KILO = 64'h400;
	localparam logic [63:0] LOW32  = 64'hFFFF_FFFF;
	localparam logic [63:0] TOP64  = 64'hF000_0000_0000_0000;
	localparam logic [63:0] TOP32  = 64'hF000_0000;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ITER,
		S_FINISH,
		S_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_key;   // capture accepted word
		logic apply_key;  // perform the immediate part of the key
		logic start_op;   // set up multicycle evaluation
		logic iter_step;  // one mul/div bit step
		logic finish;     // commit evaluation result
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic need_eval;  // key requires evaluating pending op
		logic last_iter;  // iteration counter at end, or no mul/div pending
	} stat_t;

endpackage
`default_nettype wire

[rtl/core/hex_calculator_key_engine.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hex_calculator_key_engine: key engine of a programmer's calculator
// One key word in, one display word out.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave channel s_axis_*: one key press per word. tdata holds, from the
//    lowest bit up, digit_value[3:0] and operator_code[3:0]; tuser holds
//    command[3:0].
//  - Master channel m_axis_*: one result word per key. tdata holds
//    shown_value[63:0], wide_mode, decimal_format, error_flag, zero filled.
//  - Sequence: keys that do not evaluate pass S_DECODE and then S_OUT;
//    an evaluated operator passes S_DECODE, S_ITER, S_FINISH and S_OUT,
//    and multiply or divide stay in S_ITER for the 64-step bit-serial
//    mul/div loop.
//  - Throughput: one key at a time; the next key is taken in the cycle after
//    the result is taken.
//  - Reset clears all calculator state: display and operand zero, nothing
//    pending, 32-bit hex mode, no error.
//  - A stalled receiver holds the result word stable; no key is accepted.
// ----------------------------------------------------------------------------
module hex_calculator_key_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // digit_value, operator_code
	input  wire logic [3:0]  s_axis_tuser,   // command
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata    // shown_value, wide, decimal, error
);
	import hck_pkg::*;

	ctrl_t ctrl;
	stat_t stat;
	logic  in_fire, out_fire;
	logic [63:0] shown_value;
	logic wide_mode, decimal_format, error_flag;

	// accept on handshake
	assign in_fire  = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	hck_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .out_fire(out_fire),
		.stat(stat), .ctrl(ctrl), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
	);

	hck_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
		.command(s_axis_tuser), .digit_value(s_axis_tdata[3:0]),
		.operator_code(s_axis_tdata[7:4]), .stat(stat),
		.shown_value(shown_value), .wide_mode(wide_mode),
		.decimal_format(decimal_format), .error_flag(error_flag)
	);

	// pack the result word
	assign m_axis_tdata = {5'd0, error_flag, decimal_format, wide_mode, shown_value};
endmodule
`default_nettype wire

[rtl/core/hck_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hck_ctrl: controller of the key engine
// Sequences capture, decode, iterative evaluation and result delivery.
// ----------------------------------------------------------------------------
module hck_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_fire,
	input  wire logic          out_fire,
	input  wire hck_pkg::stat_t stat,
	output hck_pkg::ctrl_t     ctrl,
	output logic               in_ready,
	output logic               out_valid
);
	import hck_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_fire) state_d = S_DECODE;
			S_DECODE: state_d = stat.need_eval ? S_ITER : S_OUT;
			S_ITER:   if (stat.last_iter) state_d = S_FINISH;
			S_FINISH: state_d = S_OUT;
			S_OUT:    if (out_fire) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ctrl.load_key = in_fire;
			end
			S_DECODE: begin
				ctrl.apply_key = !stat.need_eval;
				ctrl.start_op = stat.need_eval;
			end
			S_ITER:   ctrl.iter_step = 1'b1;
			S_FINISH: begin
				ctrl.finish = 1'b1;
			end
			S_OUT:    out_valid = 1'b1;
			default:  ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/hck_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hck_dpath: datapath of the key engine
// Calculator registers, shift-add multiplier and restoring divider.
// ----------------------------------------------------------------------------
module hck_dpath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hck_pkg::ctrl_t ctrl,
	input  wire logic [3:0]    command,
	input  wire logic [3:0]    digit_value,
	input  wire logic [3:0]    operator_code,
	output hck_pkg::stat_t     stat,
	output logic [63:0]        shown_value,
	output logic               wide_mode,
	output logic               decimal_format,
	output logic               error_flag
);
	import hck_pkg::*;

	logic [63:0] disp_q, stor_q;
	logic [3:0]  pend_q;
	logic [1:0]  entry_q;
	logic        wide_q, dec_q, err_q;
	logic [3:0]  cmd_q, dig_q, opc_q;
	logic [63:0] a_q, b_q, acc_q, rem_q;
	logic [5:0]  cnt_q;

	logic act, is_oper, oper_ok, eq_eval, need_eval, slow_op;
	assign act     = !err_q || (cmd_q == CMD_CLEAR);
	assign oper_ok = (opc_q <= OP_DIV) && (entry_q != ST_NOVALUE);
	assign is_oper = act && (cmd_q == CMD_OPER) && oper_ok;
	assign eq_eval = act && (cmd_q == CMD_EQUALS) && (pend_q <= OP_DIV)
		&& (entry_q != ST_NOVALUE);
	assign need_eval = (is_oper && pend_q <= OP_DIV) || eq_eval;
	assign slow_op = (pend_q == OP_MUL) || (pend_q == OP_DIV);
	assign stat.need_eval = need_eval;
	assign stat.last_iter = !slow_op || (cnt_q == 6'd63);

	// fast operations, or the mul/div accumulator, masked to the width
	logic [63:0] fast_r, res, mask;
	logic        div0;
	assign mask = wide_q ? '1 : LOW32;
	assign div0 = (pend_q == OP_DIV) && (b_q == '0);
	always_comb begin
		case (pend_q)
			OP_AND:  fast_r = a_q & b_q;
			OP_OR:   fast_r = a_q | b_q;
			OP_XOR:  fast_r = a_q ^ b_q;
			OP_SHL:  fast_r = (b_q >= 64'd64) ? '0 : (a_q << b_q[5:0]);
			OP_SHR:  fast_r = (b_q >= 64'd64) ? '0 : (a_q >> b_q[5:0]);
			OP_ADD:  fast_r = a_q + b_q;
			OP_SUB:  fast_r = a_q - b_q;
			OP_MUL:  fast_r = acc_q;
			OP_DIV:  fast_r = acc_q;
			default: fast_r = '0;
		endcase
		res = div0 ? '0 : (fast_r & mask);
	end

	// one bit step of multiply (MSB first) and restoring divide
	logic [63:0] mul_n, div_q_n, rem_n;
	logic [64:0] rem_sh;
	logic [65:0] trial;
	always_comb begin
		mul_n = (acc_q << 1) + (b_q[6'd63 - cnt_q] ? a_q : '0);
		rem_sh = {rem_q, a_q[6'd63 - cnt_q]};
		trial = {1'b0, rem_sh} - {2'b00, b_q};
		rem_n = trial[65] ? rem_sh[63:0] : trial[63:0];
		div_q_n = {acc_q[62:0], !trial[65]};
	end

	logic [63:0] top;
	assign top = wide_q ? TOP64 : TOP32;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp_q <= '0; stor_q <= '0; pend_q <= OP_NONE; entry_q <= ST_RESULT;
			wide_q <= 1'b0; dec_q <= 1'b0; err_q <= 1'b0; cnt_q <= '0;
			a_q <= '0; b_q <= '0; acc_q <= '0; rem_q <= '0;
		end else begin
			if (ctrl.start_op) begin
				a_q <= stor_q; b_q <= disp_q; acc_q <= '0; rem_q <= '0; cnt_q <= '0;
			end
			if (ctrl.iter_step) begin
				cnt_q <= cnt_q + 6'd1;
				if (pend_q == OP_MUL) begin
					acc_q <= mul_n;
				end else begin
					acc_q <= div_q_n; rem_q <= rem_n;
				end
			end
			if (ctrl.finish) begin
				if (div0) err_q <= 1'b1;
				if (cmd_q == CMD_OPER) begin
					disp_q <= res; stor_q <= res; pend_q <= opc_q; entry_q <= ST_NOVALUE;
				end else begin
					disp_q <= res; stor_q <= '0; pend_q <= OP_NONE; entry_q <= ST_RESULT;
				end
			end
			if (ctrl.apply_key && act) begin
				case (cmd_q)
					CMD_DIGIT: begin
						entry_q <= ST_INPUT;
						if (entry_q != ST_INPUT) disp_q <= {60'd0, dig_q};
						else if ((disp_q & top) == '0) disp_q <= {disp_q[59:0], dig_q};
					end
					CMD_GIGA: begin disp_q <= K_GIGA; entry_q <= ST_RESULT; end
					CMD_MEGA: begin disp_q <= K_MEGA; entry_q <= ST_RESULT; end
					CMD_KILO: begin disp_q <= K_KILO; entry_q <= ST_RESULT; end
					CMD_INVERT: begin disp_q <= ~disp_q & mask; entry_q <= ST_RESULT; end
					CMD_OPER: if (oper_ok) begin
						stor_q <= disp_q; pend_q <= opc_q; entry_q <= ST_NOVALUE;
					end
					CMD_EQUALS: begin
						stor_q <= '0; pend_q <= OP_NONE; entry_q <= ST_RESULT;
					end
					CMD_CLEAR: begin
						entry_q <= ST_RESULT; pend_q <= OP_NONE; disp_q <= '0;
						stor_q <= '0; err_q <= 1'b0;
					end
					CMD_CLR_ENT: if (entry_q == ST_INPUT) disp_q <= '0;
					CMD_WIDTH: begin
						wide_q <= !wide_q;
						if (wide_q) begin
							disp_q <= disp_q & LOW32; stor_q <= stor_q & LOW32;
						end
					end
					CMD_FORMAT: dec_q <= !dec_q;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_key) begin
			cmd_q <= command; dig_q <= digit_value; opc_q <= operator_code;
		end
	end

	// output values read straight from the state, stable while S_OUT holds
	assign shown_value    = disp_q;
	assign wide_mode      = wide_q;
	assign decimal_format = dec_q;
	assign error_flag     = err_q;
endmodule
`default_nettype wire

[tb/sv/tb_hex_calculator_key_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hex_calculator_key_engine: self-checking bench of the calculator key engine
// Drives key words on the slave stream, predicts every display word with an
// in-bench model of the calculator, and compares it field by field with the
// master stream. Directed keys come first, then random key sequences.
// ----------------------------------------------------------------------------
module tb_hex_calculator_key_engine;
	import hck_pkg::*;

	localparam int N_RANDOM = 930;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // digit_value[3:0], operator_code[7:4]
	logic [3:0]  s_axis_tuser;   // command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // shown_value[63:0], wide, decimal, error

	typedef struct packed {
		logic [63:0] shown;
		logic        wide;
		logic        dec;
		logic        err;
	} disp_t;

	typedef struct {
		logic [3:0] cmd;
		logic [3:0] dig;
		logic [3:0] opc;
		logic       has_exp;
		disp_t      exp_word;
	} key_row_t;

	// calculator state as the bench predicts it
	logic [63:0] calc_disp, calc_stored;
	logic [3:0]  calc_pend;
	logic [1:0]  calc_entry;
	logic        calc_wide, calc_dec, calc_err;

	disp_t display_q[$];
	int    n_errors = 0;
	int    n_results = 0;
	int    n_div0 = 0;
	int    n_muldiv = 0;
	bit    stim_done = 0;
	bit    hold_rx = 0;

	hex_calculator_key_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit: sized for the slowest key plus the random gaps on both sides
	initial begin
		#(12 * 400000);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void calc_reset();
		calc_disp   = '0;
		calc_stored = '0;
		calc_pend   = OP_NONE;
		calc_entry  = ST_RESULT;
		calc_wide   = 1'b0;
		calc_dec    = 1'b0;
		calc_err    = 1'b0;
	endfunction

	// clear keeps width and format
	function automatic void calc_reset_keep_modes();
		calc_entry  = ST_RESULT;
		calc_pend   = OP_NONE;
		calc_disp   = '0;
		calc_stored = '0;
		calc_err    = 1'b0;
	endfunction

	// evaluate a pending binary operation; divide by zero latches the error
	function automatic logic [63:0] calc_eval(logic [3:0] op, logic [63:0] a, logic [63:0] b);
		logic [63:0] r;
		if (op == OP_MUL || op == OP_DIV)
			n_muldiv++;
		if (op == OP_DIV && b == 64'd0) begin
			calc_err = 1'b1;
			n_div0++;
			return 64'd0;
		end
		case (op)
			OP_AND: r = a & b;
			OP_OR:  r = a | b;
			OP_XOR: r = a ^ b;
			OP_SHL: r = (b >= 64) ? 64'd0 : a << b[5:0];
			OP_SHR: r = (b >= 64) ? 64'd0 : a >> b[5:0];
			OP_ADD: r = a + b;
			OP_SUB: r = a - b;
			OP_MUL: r = a * b;
			OP_DIV: r = a / b;
			default: r = 64'd0;
		endcase
		if (!calc_wide)
			r &= LOW32;
		return r;
	endfunction

	// apply one key press and return the display word it must produce
	function automatic disp_t calc_key(logic [3:0] cmd, logic [3:0] dig, logic [3:0] opc);
		logic [63:0] top;
		if (!calc_err || cmd == CMD_CLEAR) begin
			case (cmd)
				CMD_DIGIT: begin
					top = calc_wide ? TOP64 : TOP32;
					if (calc_entry != ST_INPUT) begin
						calc_disp  = '0;
						calc_entry = ST_INPUT;
					end
					if ((calc_disp & top) == 64'd0)
						calc_disp = {calc_disp[59:0], dig};
				end
				CMD_GIGA: begin calc_disp = K_GIGA; calc_entry = ST_RESULT; end
				CMD_MEGA: begin calc_disp = K_MEGA; calc_entry = ST_RESULT; end
				CMD_KILO: begin calc_disp = K_KILO; calc_entry = ST_RESULT; end
				CMD_INVERT: begin
					calc_disp = ~calc_disp;
					if (!calc_wide)
						calc_disp &= LOW32;
					calc_entry = ST_RESULT;
				end
				CMD_OPER: begin
					if (opc <= OP_DIV && calc_entry != ST_NOVALUE) begin
						if (calc_pend <= OP_DIV)
							calc_disp = calc_eval(calc_pend, calc_stored, calc_disp);
						calc_stored = calc_disp;
						calc_pend   = opc;
						calc_entry  = ST_NOVALUE;
					end
				end
				CMD_EQUALS: begin
					if (calc_pend <= OP_DIV && calc_entry != ST_NOVALUE)
						calc_disp = calc_eval(calc_pend, calc_stored, calc_disp);
					calc_stored = '0;
					calc_pend   = OP_NONE;
					calc_entry  = ST_RESULT;
				end
				CMD_CLEAR: begin
					calc_reset_keep_modes();
				end
				CMD_CLR_ENT: begin
					if (calc_entry == ST_INPUT)
						calc_disp = '0;
				end
				CMD_WIDTH: begin
					calc_wide = ~calc_wide;
					if (!calc_wide) begin
						calc_disp   &= LOW32;
						calc_stored &= LOW32;
					end
				end
				CMD_FORMAT: calc_dec = ~calc_dec;
				default: ;
			endcase
		end
		return '{calc_disp, calc_wide, calc_dec, calc_err};
	endfunction

	// directed keys; expected words typed in where obvious
	key_row_t key_table[] = '{
		'{CMD_FORMAT,  4'h0, 4'h0, 1, '{64'd0, 1'b0, 1'b1, 1'b0}},
		'{CMD_FORMAT,  4'h0, 4'h0, 1, '{64'd0, 1'b0, 1'b0, 1'b0}},
		'{CMD_GIGA,    4'h0, 4'h0, 1, '{K_GIGA, 1'b0, 1'b0, 1'b0}},
		'{CMD_MEGA,    4'h0, 4'h0, 1, '{K_MEGA, 1'b0, 1'b0, 1'b0}},
		'{CMD_KILO,    4'h0, 4'h0, 1, '{K_KILO, 1'b0, 1'b0, 1'b0}},
		'{CMD_INVERT,  4'h0, 4'h0, 1, '{64'hFFFF_FBFF, 1'b0, 1'b0, 1'b0}},
		'{CMD_DIGIT,   4'hF, 4'h0, 1, '{64'hF, 1'b0, 1'b0, 1'b0}},
		'{CMD_DIGIT,   4'hA, 4'hF, 0, '0},
		'{CMD_CLR_ENT, 4'h0, 4'h0, 1, '{64'd0, 1'b0, 1'b0, 1'b0}},
		'{CMD_INVERT,  4'h0, 4'h0, 0, '0},
		'{CMD_DIGIT,   4'h1, 4'h0, 0, '0},   // after a result: starts a new entry
		'{CMD_WIDTH,   4'h0, 4'h0, 0, '0},
		'{CMD_INVERT,  4'h0, 4'h0, 0, '0},
		'{CMD_OPER,    4'h0, OP_SHL, 0, '0},
		'{CMD_OPER,    4'h0, OP_ADD, 0, '0},   // no value yet: ignored
		'{CMD_OPER,    4'h0, 4'd12, 0, '0},    // unknown operator
		'{CMD_INVERT,  4'h0, 4'h0, 0, '0},
		'{CMD_EQUALS,  4'h0, 4'h0, 0, '0},     // shift left by one
		'{4'd13,       4'h5, 4'h5, 0, '0},     // unknown command
		'{CMD_OPER,    4'h0, OP_MUL, 0, '0},
		'{CMD_GIGA,    4'h0, 4'h0, 0, '0},
		'{CMD_EQUALS,  4'h0, 4'h0, 0, '0},
		'{CMD_OPER,    4'h0, OP_DIV, 0, '0},
		'{CMD_DIGIT,   4'h0, 4'h0, 0, '0},     // zero divisor
		'{CMD_EQUALS,  4'h0, 4'h0, 1, '{64'd0, 1'b1, 1'b0, 1'b1}},
		'{CMD_DIGIT,   4'h3, 4'h0, 1, '{64'd0, 1'b1, 1'b0, 1'b1}},
		'{CMD_CLEAR,   4'h0, 4'h0, 1, '{64'd0, 1'b1, 1'b0, 1'b0}}
	};

	// drive one key word: wait a random gap, offer it, hold until accepted
	task automatic send_key(logic [3:0] cmd, logic [3:0] dig, logic [3:0] opc,
			bit has_exp, disp_t exp_word);
		int gap;
		disp_t pred;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {opc, dig};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pred = calc_key(cmd, dig, opc);
		if (has_exp && pred !== exp_word)
			$display("note: table row disagrees with prediction for cmd %0d", cmd);
		display_q.push_back(has_exp ? exp_word : pred);
	endtask

	// random key with realistic mix: mostly digits and operators
	task automatic send_random_key();
		int pick;
		logic [3:0] cmd, dig, opc;
		pick = $urandom_range(0, 99);
		dig  = 4'($urandom_range(0, 15));
		opc  = 4'($urandom_range(0, 8));
		if (pick < 45)      cmd = CMD_DIGIT;
		else if (pick < 62) cmd = CMD_OPER;
		else if (pick < 72) cmd = CMD_EQUALS;
		else if (pick < 75) cmd = CMD_CLEAR;
		else if (pick < 78) cmd = CMD_CLR_ENT;
		else if (pick < 81) cmd = CMD_WIDTH;
		else if (pick < 83) cmd = CMD_FORMAT;
		else if (pick < 86) cmd = CMD_INVERT;
		else if (pick < 92) cmd = 4'($urandom_range(CMD_GIGA, CMD_KILO));
		else if (pick < 95) begin
			cmd = CMD_OPER;
			opc = 4'($urandom_range(9, 15));
		end else
			cmd = 4'($urandom_range(0, 15));
		// keep the error latch from sticking around too long
		if (calc_err && $urandom_range(0, 2) == 0)
			cmd = CMD_CLEAR;
		send_key(cmd, dig, opc, 1'b0, '0);
	endtask

	// sender
	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		arst_n        = 1'b0;
		calc_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (key_table[i])
			send_key(key_table[i].cmd, key_table[i].dig, key_table[i].opc,
				key_table[i].has_exp, key_table[i].exp_word);
		for (int i = 0; i < N_RANDOM; i++) begin
			// drain pause: wait for every outstanding word
			if (i == 300) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (display_q.size() != 0)
					@(posedge clk);
			end
			if (i == 500)
				hold_rx = 1'b1;
			send_random_key();
		end
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver: random stalls, plus one long hold while keys are offered
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_rx) begin
				hold_rx = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 16);
				if (stall != 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid)
				@(posedge clk);
		end
	end

	// checker: compare each accepted word with the oldest prediction
	always @(posedge clk) begin
		disp_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tdata[63:0], m_axis_tdata[64], m_axis_tdata[65], m_axis_tdata[66]};
			if (display_q.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected word %h", m_axis_tdata);
			end else begin
				want = display_q.pop_front();
				n_results++;
				if (got !== want) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch #%0d: value %h/%h wide %b/%b dec %b/%b err %b/%b",
							n_results, want.shown, got.shown, want.wide, got.wide,
							want.dec, got.dec, want.err, got.err);
				end
			end
		end
	end

	// end of run
	initial begin
		@(posedge stim_done);
		while (display_q.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		$display("covered %0d display words, %0d mul/div evaluations, %0d divides by zero",
			n_results, n_muldiv, n_div0);
		if (n_errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
rtl/core/hck_pkg.sv
rtl/core/hck_ctrl.sv
rtl/core/hck_dpath.sv
rtl/core/hex_calculator_key_engine.sv
tb/sv/tb_hex_calculator_key_engine.sv
